### rtl/touch_slider_gesture_control_defines.svh
// Assertion helpers used by the touch slider top-level file.
`ifndef TOUCH_SLIDER_GESTURE_CONTROL_DEFINES_SVH
`define TOUCH_SLIDER_GESTURE_CONTROL_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TSGC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("touch slider check failed");

// Next-cycle implication, disabled while reset is held.
`define TSGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("touch slider check failed");

`endif

### rtl/tsgc_pkg.sv
`default_nettype none
package tsgc_pkg;

    localparam int PAD_COUNT   = 7;
    localparam int SAMPLE_BITS = 10;
    localparam int RISE_BITS   = SAMPLE_BITS + 1;
    localparam int PAD_BITS    = 3;
    localparam int LEVEL_BITS  = 3;
    localparam int LINE_BITS   = 3;
    localparam int TIME_BITS   = 32;
    localparam int THRESH_BITS = 10;
    localparam int TIMEOUT_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOUCH_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_TIMEOUT     = 2'd1;

    localparam logic KIND_CAL  = 1'b0;
    localparam logic KIND_OPER = 1'b1;

    localparam logic [THRESH_BITS-1:0]  THRESH_RESET  = 10'd8;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [PAD_BITS-1:0]     PREV_PAD_RESET = 3'd4;
    localparam logic [PAD_BITS-1:0]     NO_PAD = 3'd0;
    localparam logic [LEVEL_BITS-1:0]   LEVEL_DARK = 3'd0;
    localparam logic [LEVEL_BITS-1:0]   LEVEL_AUX  = 3'd7;

    typedef logic signed [RISE_BITS-1:0] rise_t;

    typedef struct packed {
        logic                 kind;
        logic [PAD_BITS-1:0]  pad;
        logic [TIME_BITS-1:0] now_ms;
    } step_t;

    typedef struct packed {
        logic [PAD_BITS-1:0]   touched_pad;
        logic                  tap_event;
        logic                  slide_event;
        logic                  power_state;
        logic [LEVEL_BITS-1:0] shown_level;
        logic [LINE_BITS-1:0]  pin_enable;
        logic [LINE_BITS-1:0]  pin_level;
        logic                  aux_led;
        logic                  status_led;
    } result_t;

    // Charlieplex line enables for each LED level.
    function automatic logic [LINE_BITS-1:0] line_enable(input logic [LEVEL_BITS-1:0] lv);
        logic [LINE_BITS-1:0] en;
        case (lv)
            3'd1, 3'd2: en = 3'b011;
            3'd3, 3'd4: en = 3'b110;
            3'd5, 3'd6: en = 3'b101;
            default:    en = 3'b000;
        endcase
        return en;
    endfunction

    // Driven levels of the enabled lines; released lines report low.
    function automatic logic [LINE_BITS-1:0] line_level(input logic [LEVEL_BITS-1:0] lv);
        logic [LINE_BITS-1:0] dv;
        case (lv)
            3'd1, 3'd4: dv = 3'b010;
            3'd2, 3'd6: dv = 3'b001;
            3'd3, 3'd5: dv = 3'b100;
            default:    dv = 3'b000;
        endcase
        return dv;
    endfunction

endpackage
`default_nettype wire

### rtl/touch_slider_gesture_control.sv
// An accepted item is registered in the rise registers and then passes into the
// result register, whose contents stay valid until they are taken.
// Throughput: one item per cycle unless the result side stalls; the rise registers
// and the result register form a two-deep pipeline that holds its contents during a stall.
// Reset (aresetn low, synchronous) clears all pad baselines, sets the previous pad
// to four, lights on, level dark, threshold 8 and tap timeout 500 ms.
`default_nettype none
`include "touch_slider_gesture_control_defines.svh"
module touch_slider_gesture_control (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tsgc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tsgc_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_kind,
    input  wire logic [tsgc_pkg::SAMPLE_BITS-1:0]     s_pad_sample_1,
    input  wire logic [tsgc_pkg::SAMPLE_BITS-1:0]     s_pad_sample_2,
    input  wire logic [tsgc_pkg::SAMPLE_BITS-1:0]     s_pad_sample_3,
    input  wire logic [tsgc_pkg::SAMPLE_BITS-1:0]     s_pad_sample_4,
    input  wire logic [tsgc_pkg::SAMPLE_BITS-1:0]     s_pad_sample_5,
    input  wire logic [tsgc_pkg::SAMPLE_BITS-1:0]     s_pad_sample_6,
    input  wire logic [tsgc_pkg::SAMPLE_BITS-1:0]     s_pad_sample_7,
    input  wire logic [tsgc_pkg::TIME_BITS-1:0]       s_now_ms,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [tsgc_pkg::PAD_BITS-1:0]             m_touched_pad,
    output logic                                      m_tap_event,
    output logic                                      m_slide_event,
    output logic                                      m_power_state,
    output logic [tsgc_pkg::LEVEL_BITS-1:0]           m_shown_level,
    output logic [tsgc_pkg::LINE_BITS-1:0]            m_pin_enable,
    output logic [tsgc_pkg::LINE_BITS-1:0]            m_pin_level,
    output logic                                      m_aux_led,
    output logic                                      m_status_led
);

    // Configuration registers. Writes are always taken; unknown indexes are ignored.
    logic [tsgc_pkg::THRESH_BITS-1:0]  threshold_reg, threshold_next;
    logic [tsgc_pkg::TIMEOUT_BITS-1:0] timeout_reg, timeout_next;

    // Pipeline control: stage one holds the lane rises, stage two the result.
    logic                            a_valid_reg, a_valid_next;
    logic                            a_kind_reg;
    logic [tsgc_pkg::TIME_BITS-1:0]  a_now_reg;
    logic                            m_valid_reg, m_valid_next;
    logic                            out_free;
    logic                            a_adv;
    logic                            s_accept;
    logic                            cal_en;

    logic [tsgc_pkg::SAMPLE_BITS-1:0] samples [tsgc_pkg::PAD_COUNT];
    tsgc_pkg::rise_t                  rises   [tsgc_pkg::PAD_COUNT];
    logic [tsgc_pkg::PAD_BITS-1:0]    cur_pad;
    tsgc_pkg::step_t                  step;
    tsgc_pkg::result_t                result;

    assign cfg_ready = 1'b1;

    always_comb begin
        threshold_next = threshold_reg;
        timeout_next   = timeout_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tsgc_pkg::CFG_TOUCH_THRESHOLD:
                    threshold_next = cfg_data[tsgc_pkg::THRESH_BITS-1:0];
                tsgc_pkg::CFG_TAP_TIMEOUT:
                    timeout_next   = cfg_data[tsgc_pkg::TIMEOUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The result register is free when empty or being taken this cycle, and the
    // rise stage is free when empty or moving on, so a full pipeline still takes
    // an item in every cycle the result side keeps up.
    assign out_free = !m_valid_reg || m_ready;
    assign a_adv    = a_valid_reg && out_free;
    assign s_ready  = !a_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;
    assign cal_en   = s_accept && (s_kind == tsgc_pkg::KIND_CAL);

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (a_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= tsgc_pkg::THRESH_RESET;
            timeout_reg   <= tsgc_pkg::TIMEOUT_RESET;
            a_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            threshold_reg <= threshold_next;
            timeout_reg   <= timeout_next;
            a_valid_reg   <= a_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        if (s_accept) begin
            a_kind_reg <= s_kind;
            a_now_reg  <= s_now_ms;
        end
    end

    assign samples[0] = s_pad_sample_1;
    assign samples[1] = s_pad_sample_2;
    assign samples[2] = s_pad_sample_3;
    assign samples[3] = s_pad_sample_4;
    assign samples[4] = s_pad_sample_5;
    assign samples[5] = s_pad_sample_6;
    assign samples[6] = s_pad_sample_7;

    // One lane per pad. A calibration item updates the baselines as it is taken,
    // so the next item already sees them.
    for (genvar g = 0; g < tsgc_pkg::PAD_COUNT; g++) begin : g_lane
        tsgc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .load_en (s_accept),
            .cal_en  (cal_en),
            .sample  (samples[g]),
            .rise    (rises[g])
        );
    end

    tsgc_merge u_merge (
        .rises     (rises),
        .threshold (threshold_reg),
        .pad       (cur_pad)
    );

    assign step.kind   = a_kind_reg;
    assign step.pad    = cur_pad;
    assign step.now_ms = a_now_reg;

    // Gesture state only moves when an item passes into the result register.
    tsgc_gesture u_gesture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (a_adv),
        .step    (step),
        .timeout (timeout_reg),
        .result  (result)
    );

    assign m_valid       = m_valid_reg;
    assign m_touched_pad = result.touched_pad;
    assign m_tap_event   = result.tap_event;
    assign m_slide_event = result.slide_event;
    assign m_power_state = result.power_state;
    assign m_shown_level = result.shown_level;
    assign m_pin_enable  = result.pin_enable;
    assign m_pin_level   = result.pin_level;
    assign m_aux_led     = result.aux_led;
    assign m_status_led  = result.status_led;

    // The indicator always mirrors the power state.
    `TSGC_ASSERT_NOW(a_status_mirrors_power, aclk, aresetn, m_valid, m_status_led == !m_power_state)
    // A slide disarms the tap timer, so both can never be reported together.
    `TSGC_ASSERT_NOW(a_no_tap_with_slide, aclk, aresetn, m_valid, !(m_tap_event && m_slide_event))
    // With power off every line is released.
    `TSGC_ASSERT_NOW(a_dark_when_off, aclk, aresetn, m_valid && !m_power_state,
        m_shown_level == tsgc_pkg::LEVEL_DARK && m_pin_enable == '0)
    // A rise stage item blocked by a full result register is kept, not dropped.
    `TSGC_ASSERT_NEXT(a_stage_holds, aclk, aresetn, a_valid_reg && !out_free, a_valid_reg)

endmodule
`default_nettype wire

### rtl/tsgc_lane.sv
`default_nettype none
// One pad: keeps the baseline and registers the baseline-corrected rise.
module tsgc_lane (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              load_en,
    input  wire logic                              cal_en,
    input  wire logic [tsgc_pkg::SAMPLE_BITS-1:0]  sample,
    output tsgc_pkg::rise_t                        rise
);

    logic [tsgc_pkg::SAMPLE_BITS-1:0] baseline_reg;
    logic [tsgc_pkg::SAMPLE_BITS-1:0] baseline_next;
    tsgc_pkg::rise_t                  rise_reg;
    tsgc_pkg::rise_t                  rise_next;

    always_comb begin
        baseline_next = baseline_reg;
        if (cal_en && (sample > baseline_reg)) begin
            baseline_next = sample;
        end
        rise_next = $signed({1'b0, sample}) - $signed({1'b0, baseline_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= '0;
        end else begin
            baseline_reg <= baseline_next;
        end
        if (load_en) begin
            rise_reg <= rise_next;
        end
    end

    assign rise = rise_reg;

endmodule
`default_nettype wire

### rtl/tsgc_merge.sv
`default_nettype none
// Picks the pad with the highest rise above the threshold; ties go to the earlier pad.
module tsgc_merge (
    input  wire tsgc_pkg::rise_t                   rises [tsgc_pkg::PAD_COUNT],
    input  wire logic [tsgc_pkg::THRESH_BITS-1:0]  threshold,
    output logic [tsgc_pkg::PAD_BITS-1:0]          pad
);

    tsgc_pkg::rise_t                best;
    logic [tsgc_pkg::PAD_BITS-1:0]  cur;

    always_comb begin
        best = $signed({1'b0, threshold});
        cur  = tsgc_pkg::NO_PAD;
        for (int i = 0; i < tsgc_pkg::PAD_COUNT; i++) begin
            if (rises[i] > best) begin
                best = rises[i];
                cur  = tsgc_pkg::PAD_BITS'(i + 1);
            end
        end
        pad = cur;
    end

endmodule
`default_nettype wire

### rtl/tsgc_gesture.sv
`default_nettype none
// Slide and tap recognition, power and level state, and the result register.
module tsgc_gesture (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               step_en,
    input  wire tsgc_pkg::step_t                    step,
    input  wire logic [tsgc_pkg::TIMEOUT_BITS-1:0]  timeout,
    output tsgc_pkg::result_t                       result
);

    logic [tsgc_pkg::PAD_BITS-1:0]   prev_pad_reg, prev_pad_next;
    logic                            armed_reg, armed_next;
    logic [tsgc_pkg::TIME_BITS-1:0]  start_reg, start_next;
    logic                            lights_reg, lights_next;
    logic [tsgc_pkg::LEVEL_BITS-1:0] remembered_reg, remembered_next;
    logic [tsgc_pkg::LEVEL_BITS-1:0] driven_reg, driven_next;
    logic                            indicator_reg, indicator_next;
    tsgc_pkg::result_t               result_reg, result_next;
    logic                            tap, slide;
    logic [tsgc_pkg::TIME_BITS-1:0]  elapsed;

    always_comb begin
        prev_pad_next   = prev_pad_reg;
        armed_next      = armed_reg;
        start_next      = start_reg;
        lights_next     = lights_reg;
        remembered_next = remembered_reg;
        driven_next     = driven_reg;
        indicator_next  = indicator_reg;
        tap             = 1'b0;
        slide           = 1'b0;
        elapsed         = '0;

        if (step.kind == tsgc_pkg::KIND_OPER) begin
            prev_pad_next = step.pad;
            slide = (prev_pad_reg != tsgc_pkg::NO_PAD) && (step.pad != tsgc_pkg::NO_PAD)
                    && (prev_pad_reg != step.pad);
            if (slide) begin
                armed_next = 1'b0;
            end
            // A new touch arms the tap timer from this frame's time.
            if ((prev_pad_reg == tsgc_pkg::NO_PAD) && (step.pad != tsgc_pkg::NO_PAD)) begin
                armed_next = 1'b1;
                start_next = step.now_ms;
            end
            elapsed = step.now_ms - start_next;
            if (armed_next && ((step.pad == tsgc_pkg::NO_PAD)
                    || (elapsed > {{(tsgc_pkg::TIME_BITS - tsgc_pkg::TIMEOUT_BITS){1'b0}},
                                   timeout}))) begin
                tap        = 1'b1;
                armed_next = 1'b0;
            end

            if (tap && lights_reg) begin
                lights_next    = 1'b0;
                indicator_next = 1'b1;
                driven_next    = tsgc_pkg::LEVEL_DARK;
            end else if ((tap || slide) && !lights_reg) begin
                lights_next    = 1'b1;
                indicator_next = 1'b0;
                driven_next    = remembered_reg;
            end
            if (slide) begin
                remembered_next = step.pad;
                driven_next     = step.pad;
            end
        end

        result_next.touched_pad = (step.kind == tsgc_pkg::KIND_OPER) ? step.pad
                                                                     : tsgc_pkg::NO_PAD;
        result_next.tap_event   = tap;
        result_next.slide_event = slide;
        result_next.power_state = lights_next;
        result_next.shown_level = driven_next;
        result_next.pin_enable  = tsgc_pkg::line_enable(driven_next);
        result_next.pin_level   = tsgc_pkg::line_level(driven_next);
        result_next.aux_led     = (driven_next == tsgc_pkg::LEVEL_AUX);
        result_next.status_led  = indicator_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pad_reg   <= tsgc_pkg::PREV_PAD_RESET;
            armed_reg      <= 1'b0;
            start_reg      <= '0;
            lights_reg     <= 1'b1;
            remembered_reg <= tsgc_pkg::LEVEL_DARK;
            driven_reg     <= tsgc_pkg::LEVEL_DARK;
            indicator_reg  <= 1'b0;
        end else if (step_en) begin
            prev_pad_reg   <= prev_pad_next;
            armed_reg      <= armed_next;
            start_reg      <= start_next;
            lights_reg     <= lights_next;
            remembered_reg <= remembered_next;
            driven_reg     <= driven_next;
            indicator_reg  <= indicator_next;
        end
        if (step_en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire
